// File: hdl/scp_pkg.sv
// Package for the semicolon command parser: shared constants, the control and
// status structs between controller and datapath, and the character helpers.
// No dependencies.
package scp_pkg;

    localparam int MAX_MESSAGE_DEF = 32;
    localparam int MAX_VALUE_DEF   = 16;

    localparam int ID_W       = 16;
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_NODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_FUNC = 2'd1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FEW      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NODE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FUNC     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_VALUE    = 3'd5;

    // Number parser phases.
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    localparam int ACC_W = 21;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 21'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -21'sd32768;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_SHOW
    } state_t;

    typedef struct packed {
        logic take_byte;
        logic rd_en;
        logic advance;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

    typedef struct packed {
        logic [ID_W-1:0] acc;
        logic [1:0]      phase;
        logic            neg;
    } num_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_value_char(input logic [CHAR_W-1:0] c);
        return is_digit(c) || (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)
            || (c == CH_DOT) || is_space(c);
    endfunction

    // One byte of an atoi style parse with 16-bit saturation.
    function automatic num_t number_byte(input num_t st, input logic [CHAR_W-1:0] c);
        num_t r;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] d;
        logic stop;
        r = st;
        stop = 1'b0;
        a = '0;
        d = '0;
        if (r.phase == PH_SPACE) begin
            if (is_space(c)) begin
                stop = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                r.neg = (c == CH_MINUS);
                r.phase = PH_DIGITS;
                stop = 1'b1;
            end else begin
                r.phase = PH_DIGITS;
            end
        end
        if (!stop && r.phase == PH_DIGITS) begin
            if (is_digit(c)) begin
                a = $signed({{(ACC_W-ID_W){r.acc[ID_W-1]}}, r.acc}) * 21'sd10;
                d = $signed({{(ACC_W-CHAR_W){1'b0}}, c - CH_ZERO});
                if (r.neg) begin
                    a = a - d;
                    if (a < SAT_MIN) a = SAT_MIN;
                end else begin
                    a = a + d;
                    if (a > SAT_MAX) a = SAT_MAX;
                end
                r.acc = a[ID_W-1:0];
            end else begin
                r.phase = PH_DONE;
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/scp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/scp_ctrl.sv
// Controller of the semicolon command parser: sequences byte intake and the
// readout of the result run. Depends on scp_pkg.
module scp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_end_of_message,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  scp_pkg::sts_t sts,
    output scp_pkg::cmd_t cmd
);

    scp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scp_pkg::S_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scp_pkg::S_RUN: begin
                if (s_valid && s_end_of_message) state_next = scp_pkg::S_READ;
            end
            scp_pkg::S_READ: begin
                state_next = scp_pkg::S_SHOW;
            end
            scp_pkg::S_SHOW: begin
                if (m_ready) begin
                    state_next = sts.last ? scp_pkg::S_RUN : scp_pkg::S_READ;
                end
            end
            default: state_next = scp_pkg::S_RUN;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            scp_pkg::S_RUN: begin
                s_ready = 1'b1;
                cmd.take_byte = s_valid;
            end
            scp_pkg::S_READ: begin
                cmd.rd_en = 1'b1;
            end
            scp_pkg::S_SHOW: begin
                m_valid = 1'b1;
                // The final transfer of a run also returns the message state to reset.
                cmd.clear   = m_ready && sts.last;
                cmd.advance = m_ready && !sts.last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/scp_datapath.sv
// Datapath of the semicolon command parser: tokenizer, number parsers, value
// store, configuration registers and result fields. Depends on scp_pkg, scp_ram.
module scp_datapath #(
    parameter int MAX_MESSAGE = scp_pkg::MAX_MESSAGE_DEF,
    parameter int MAX_VALUE   = scp_pkg::MAX_VALUE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  scp_pkg::cmd_t                      cmd,
    output scp_pkg::sts_t                      sts,
    input  logic [scp_pkg::CHAR_W-1:0]         char_in,
    input  logic                               cfg_we,
    input  logic [scp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic signed [scp_pkg::ID_W-1:0]    node_id,
    output logic signed [scp_pkg::ID_W-1:0]    func_id,
    output logic [scp_pkg::STATUS_W-1:0]       status,
    output logic [scp_pkg::CHAR_W-1:0]         value_char,
    output logic                               char_valid,
    output logic                               last
);

    localparam int BCW = $clog2(MAX_MESSAGE + 2);
    localparam int VLW = $clog2(MAX_VALUE + 1);
    localparam int AW  = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;

    logic [scp_pkg::ID_W-1:0] inv_node_reg, inv_func_reg;
    logic [BCW-1:0] byte_count_reg, byte_count_next;
    logic [1:0]     token_reg, token_next;
    logic           inside_reg, inside_next;
    logic           ended_reg, ended_next;
    logic [1:0]     phase_reg, phase_next;
    logic           neg_reg, neg_next;
    logic [scp_pkg::ID_W-1:0] node_acc_reg, node_acc_next;
    logic [scp_pkg::ID_W-1:0] func_acc_reg, func_acc_next;
    logic [VLW-1:0] vlen_reg, vlen_next;
    logic           chars_ok_reg, chars_ok_next;
    logic [VLW-1:0] k_reg, k_next;

    logic           ram_we;
    logic [scp_pkg::CHAR_W-1:0] ram_rdata;
    scp_pkg::num_t  num_in, num_out;
    logic           text_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_node_reg <= '1;
            inv_func_reg <= '1;
        end else if (cfg_we) begin
            if (cfg_index == scp_pkg::CFG_INVALID_NODE) inv_node_reg <= cfg_data;
            if (cfg_index == scp_pkg::CFG_INVALID_FUNC) inv_func_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            token_reg      <= '0;
            inside_reg     <= 1'b0;
            ended_reg      <= 1'b0;
            phase_reg      <= scp_pkg::PH_SPACE;
            neg_reg        <= 1'b0;
            node_acc_reg   <= '0;
            func_acc_reg   <= '0;
            vlen_reg       <= '0;
            chars_ok_reg   <= 1'b1;
            k_reg          <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            token_reg      <= token_next;
            inside_reg     <= inside_next;
            ended_reg      <= ended_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            node_acc_reg   <= node_acc_next;
            func_acc_reg   <= func_acc_next;
            vlen_reg       <= vlen_next;
            chars_ok_reg   <= chars_ok_next;
            k_reg          <= k_next;
        end
    end

    // A fresh token restarts the number parser before its first byte.
    assign num_in.acc   = (token_reg == 2'd0) ? node_acc_reg : func_acc_reg;
    assign num_in.phase = inside_reg ? phase_reg : scp_pkg::PH_SPACE;
    assign num_in.neg   = inside_reg ? neg_reg : 1'b0;
    assign num_out      = scp_pkg::number_byte(num_in, char_in);

    assign text_byte = cmd.take_byte && !ended_reg && (char_in != scp_pkg::CH_NUL);

    always_comb begin
        byte_count_next = byte_count_reg;
        token_next      = token_reg;
        inside_next     = inside_reg;
        ended_next      = ended_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        node_acc_next   = node_acc_reg;
        func_acc_next   = func_acc_reg;
        vlen_next       = vlen_reg;
        chars_ok_next   = chars_ok_reg;
        k_next          = k_reg;
        ram_we          = 1'b0;

        if (cmd.take_byte && !ended_reg && char_in == scp_pkg::CH_NUL) begin
            ended_next = 1'b1;
        end
        if (text_byte) begin
            if (byte_count_reg <= BCW'(MAX_MESSAGE)) begin
                byte_count_next = byte_count_reg + BCW'(1);
            end
            if (char_in == scp_pkg::CH_SEMI) begin
                if (inside_reg) begin
                    inside_next = 1'b0;
                    if (token_reg != 2'd3) token_next = token_reg + 2'd1;
                end
            end else begin
                inside_next = 1'b1;
                phase_next  = num_in.phase;
                neg_next    = num_in.neg;
                if (token_reg == 2'd0 || token_reg == 2'd1) begin
                    phase_next = num_out.phase;
                    neg_next   = num_out.neg;
                    if (token_reg == 2'd0) node_acc_next = num_out.acc;
                    else                   func_acc_next = num_out.acc;
                end else if (token_reg == 2'd2 && vlen_reg < VLW'(MAX_VALUE)) begin
                    ram_we    = 1'b1;
                    vlen_next = vlen_reg + VLW'(1);
                    if (!scp_pkg::is_value_char(char_in)) chars_ok_next = 1'b0;
                end
            end
        end

        if (cmd.advance) begin
            k_next = k_reg + VLW'(1);
        end
        if (cmd.clear) begin
            byte_count_next = '0;
            token_next      = '0;
            inside_next     = 1'b0;
            ended_next      = 1'b0;
            phase_next      = scp_pkg::PH_SPACE;
            neg_next        = 1'b0;
            node_acc_next   = '0;
            func_acc_next   = '0;
            vlen_next       = '0;
            chars_ok_next   = 1'b1;
            k_next          = '0;
        end
    end

    scp_ram #(
        .WIDTH (scp_pkg::CHAR_W),
        .DEPTH (MAX_VALUE),
        .AW    (AW)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (vlen_reg[AW-1:0]),
        .wdata (char_in),
        .re    (cmd.rd_en),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Result fields; the message state stays frozen while a run is read out.
    logic           too_long;
    logic [2:0]     tokens;
    logic [VLW-1:0] n_emit;

    assign too_long = byte_count_reg > BCW'(MAX_MESSAGE);
    assign tokens   = {1'b0, token_reg} + {2'b00, inside_reg};
    assign n_emit   = too_long ? '0 : vlen_reg;

    always_comb begin
        node_id = inv_node_reg;
        func_id = inv_func_reg;
        if (too_long) begin
            status = scp_pkg::ST_TOO_LONG;
        end else begin
            if (tokens >= 3'd1) node_id = node_acc_reg;
            if (tokens >= 3'd2) func_id = func_acc_reg;
            status = scp_pkg::ST_OK;
            if (tokens < 3'd3)          status = scp_pkg::ST_FEW;
            if (node_id == inv_node_reg) status = scp_pkg::ST_NODE;
            if (func_id == inv_func_reg) status = scp_pkg::ST_FUNC;
            if (vlen_reg == '0 || !chars_ok_reg) status = scp_pkg::ST_VALUE;
        end
    end

    assign char_valid = (n_emit != '0);
    assign value_char = char_valid ? ram_rdata : '0;
    assign last       = !char_valid || ((k_reg + VLW'(1)) == n_emit);
    assign sts.last   = last;

endmodule

// File: hdl/semicolon_command_parser.sv
// Semicolon command parser, top level. Bytes are accepted while no run is being
// read out and are taken back to back within a message. After the end-of-message
// transfer, and after each further result transfer, the controller passes through
// S_READ, which issues the registered read of the value store, before the next
// result is shown in S_SHOW. Input is stalled during the run.
// Reset (aresetn, synchronous, active low) clears the message state and sets both
// invalid-id registers to -1. Depends on scp_pkg, scp_ctrl, scp_datapath, scp_ram.
module semicolon_command_parser #(
    parameter int MAX_MESSAGE = scp_pkg::MAX_MESSAGE_DEF,
    parameter int MAX_VALUE   = scp_pkg::MAX_VALUE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [scp_pkg::CHAR_W-1:0]         s_char_in,
    input  logic                               s_end_of_message,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [scp_pkg::ID_W-1:0]    m_node_id,
    output logic signed [scp_pkg::ID_W-1:0]    m_func_id,
    output logic [scp_pkg::STATUS_W-1:0]       m_status,
    output logic [scp_pkg::CHAR_W-1:0]         m_value_char,
    output logic                               m_char_valid,
    output logic                               m_last,
    input  logic                               cfg_we,
    input  logic [scp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    scp_pkg::cmd_t cmd;
    scp_pkg::sts_t sts;

    scp_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_end_of_message (s_end_of_message),
        .s_ready          (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .sts              (sts),
        .cmd              (cmd)
    );

    scp_datapath #(
        .MAX_MESSAGE (MAX_MESSAGE),
        .MAX_VALUE   (MAX_VALUE)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .char_in    (s_char_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .node_id    (m_node_id),
        .func_id    (m_func_id),
        .status     (m_status),
        .value_char (m_value_char),
        .char_valid (m_char_valid),
        .last       (m_last)
    );

endmodule
